@@ rtl/tfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_pkg: shared types, constants and CRC helper for the frame checker
// Frame geometry, CRC-16-CCITT constants, verdict codes and the structs
// passed between the tracker and the verdict stage.
// ----------------------------------------------------------------------------
package tfc_pkg;

    // frame layout
    localparam int FRAME_BYTES = 30;
    localparam int POS_W       = 5;
    localparam int BODY_BYTES  = FRAME_BYTES - 2;      // bytes covered by the CRC
    localparam int BODY_W      = BODY_BYTES * 8;

    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_CRC_LOW = POS_W'(FRAME_BYTES - 2);

    // header and CRC constants
    localparam logic [15:0] FRAME_MAGIC = 16'hA5A5;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] VERSION_RST = 16'h0001;

    // verdict codes
    typedef enum logic [1:0] {
        FAIL_NONE   = 2'd0,
        FAIL_HEADER = 2'd1,
        FAIL_CRC    = 2'd2
    } fail_code_t;

    // tracker -> verdict: control and check inputs
    typedef struct packed {
        logic        is_last;     // current position is the final byte
        logic [15:0] crc;         // running CRC over the body
        logic [7:0]  crc_low;     // low byte of the stored CRC
        logic [31:0] header;      // magic in [15:0], version in [31:16]
    } trk_status_t;

    // captured payload fields
    typedef struct packed {
        logic [31:0] seq;
        logic [63:0] time_raw;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] yaw;
    } trk_fields_t;

    // byte-wide CRC-16-CCITT update, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/tfc_frame_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_frame_track: byte position, running CRC and field capture
// Advances on every accepted word. Body bytes shift into one capture line,
// so after the body the header and fields sit at fixed lanes.
// ----------------------------------------------------------------------------
module tfc_frame_track (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_en,
    input  logic [7:0]           byte_in,
    output tfc_pkg::trk_status_t status,
    output tfc_pkg::trk_fields_t fields
);
    import tfc_pkg::*;

    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [15:0]       crc_reg,  crc_next;
    logic [BODY_W-1:0] body_reg, body_next;
    logic [7:0]        crc_low_reg, crc_low_next;
    logic              is_last;
    logic              in_body;

    assign is_last = (pos_reg >= POS_LAST);
    assign in_body = (pos_reg < POS_CRC_LOW);

    // next-state logic
    always_comb begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        body_next    = body_reg;
        crc_low_next = crc_low_reg;
        if (byte_en) begin
            if (is_last) begin
                pos_next = '0;
                crc_next = CRC_INIT;
            end else begin
                pos_next = pos_reg + POS_W'(1);
                if (in_body) begin
                    crc_next  = crc_byte(crc_reg, byte_in);
                    body_next = {byte_in, body_reg[BODY_W-1:8]};
                end else begin
                    crc_low_next = byte_in;
                end
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            crc_reg <= CRC_INIT;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    // capture registers
    always_ff @(posedge aclk) begin
        body_reg    <= body_next;
        crc_low_reg <= crc_low_next;
    end

    assign status.is_last = is_last;
    assign status.crc     = crc_reg;
    assign status.crc_low = crc_low_reg;
    assign status.header  = body_reg[31:0];

    assign fields.seq      = body_reg[63:32];
    assign fields.time_raw = body_reg[127:64];
    assign fields.vel_x    = body_reg[159:128];
    assign fields.vel_y    = body_reg[191:160];
    assign fields.yaw      = body_reg[223:192];

endmodule

@@ rtl/tfc_verdict.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_verdict: header/CRC check and result register
// Forms the verdict on the final byte of a frame and holds it until the
// downstream side takes it.
// ----------------------------------------------------------------------------
module tfc_verdict (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  logic [7:0]           crc_high,
    input  logic [15:0]          version,
    input  tfc_pkg::trk_status_t status,
    input  tfc_pkg::trk_fields_t fields,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 frame_ok,
    output tfc_pkg::fail_code_t  fail_code,
    output tfc_pkg::trk_fields_t out_fields
);
    import tfc_pkg::*;

    logic        valid_reg, valid_next;
    logic        ok_reg;
    fail_code_t  code_reg;
    trk_fields_t fields_reg;
    logic        hdr_ok;
    logic        crc_ok;
    fail_code_t  code;

    // checks; header failure takes precedence
    assign hdr_ok = (status.header[15:0] == FRAME_MAGIC) &&
                    (status.header[31:16] == version);
    assign crc_ok = ({crc_high, status.crc_low} == status.crc);

    always_comb begin
        priority if (!hdr_ok) begin
            code = FAIL_HEADER;
        end else if (!crc_ok) begin
            code = FAIL_CRC;
        end else begin
            code = FAIL_NONE;
        end
    end

    // valid flag
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            ok_reg     <= hdr_ok && crc_ok;
            code_reg   <= code;
            fields_reg <= fields;
        end
    end

    assign out_valid  = valid_reg;
    assign frame_ok   = ok_reg;
    assign fail_code  = code_reg;
    assign out_fields = fields_reg;

endmodule

@@ rtl/telemetry_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_checker: CRC-16-CCITT telemetry frame checker
// Takes a stream of 30-byte frames one byte per word and gives one verdict
// word with the raw sequence, time and velocity fields per frame.
// ----------------------------------------------------------------------------
//  channel   | ports                               | word
//  ----------+-------------------------------------+---------------------------
//  input     | s_valid, s_ready, s_rx_byte         | one received byte
//  result    | m_valid, m_ready, m_frame_ok, ...   | one verdict per frame
//  config    | cfg_wr_en, cfg_wr_data              | expected version (rst 1)
//
//  One byte per cycle unless s_ready is low; each body byte is folded into
//  the CRC and capture line in the cycle it is accepted, and the verdict is
//  registered on the final byte; it appears in the cycle after that byte.
//  Reset (aresetn, synchronous) clears position, CRC and the result flag.
//  s_ready drops only on a final byte while an untaken verdict is held.
// ----------------------------------------------------------------------------
module telemetry_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_ok,
    output logic [1:0]  m_fail_reason,
    output logic [31:0] m_sequence_res,
    output logic [63:0] m_time_bits,
    output logic [31:0] m_vel_x_bits,
    output logic [31:0] m_vel_y_bits,
    output logic [31:0] m_yaw_bits
);
    import tfc_pkg::*;

    logic [15:0] version_reg;
    trk_status_t status;
    trk_fields_t fields;
    trk_fields_t out_fields;
    fail_code_t  fail_code;
    logic        s_accept;
    logic        load;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= VERSION_RST;
        end else if (cfg_wr_en) begin
            version_reg <= cfg_wr_data;
        end
    end

    // a body byte never waits on the result side
    assign s_ready  = !status.is_last || !m_valid || m_ready;
    assign s_accept = s_valid && s_ready;
    assign load     = s_accept && status.is_last;

    tfc_frame_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (s_accept),
        .byte_in (s_rx_byte),
        .status  (status),
        .fields  (fields)
    );

    tfc_verdict u_verdict (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .crc_high   (s_rx_byte),
        .version    (version_reg),
        .status     (status),
        .fields     (fields),
        .out_ready  (m_ready),
        .out_valid  (m_valid),
        .frame_ok   (m_frame_ok),
        .fail_code  (fail_code),
        .out_fields (out_fields)
    );

    assign m_fail_reason  = fail_code;
    assign m_sequence_res = out_fields.seq;
    assign m_time_bits    = out_fields.time_raw;
    assign m_vel_x_bits   = out_fields.vel_x;
    assign m_vel_y_bits   = out_fields.vel_y;
    assign m_yaw_bits     = out_fields.yaw;

    // a new verdict only follows an accepted final byte
    a_rise_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(load))
        else $error("verdict raised without a final byte");

    // frame restarts after the final byte
    a_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (!status.is_last && status.crc == CRC_INIT))
        else $error("frame state did not restart");

    // ok flag agrees with the reason code
    a_ok_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_ok == (fail_code == FAIL_NONE)))
        else $error("frame_ok and fail_reason disagree");

    // back-pressure only from a held verdict on the final byte
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (status.is_last && m_valid && !m_ready))
        else $error("input stalled without cause");

endmodule
